// ----- src/rbsi_pkg.sv -----
`timescale 1ns / 1ps

package rbsi_pkg;

    // Number formats
    localparam int FRAC_BITS    = 16;
    localparam int COORD_WIDTH  = 32;
    localparam int NORM_WIDTH   = 16;
    localparam int NORM_BITS    = 14;
    localparam int TIME_WIDTH   = FRAC_BITS + 1;
    localparam int TS_WIDTH     = FRAC_BITS + 3;
    localparam int NUM_WIDTH    = COORD_WIDTH + 2;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int MAG_BITS     = 16;
    localparam int SH_WIDTH     = $clog2(COORD_WIDTH - MAG_BITS + 1);
    localparam int SEARCH_STEPS = NORM_BITS + 1;
    localparam int ACC_WIDTH    = 64;
    localparam int SQ_WIDTH     = 2 * MAG_BITS;
    localparam int S2_WIDTH     = SQ_WIDTH + 1;
    localparam int HI_WIDTH     = COORD_WIDTH - FRAC_BITS;
    localparam int PH_WIDTH     = HI_WIDTH + TIME_WIDTH;
    localparam int PL_WIDTH     = FRAC_BITS + TIME_WIDTH;
    localparam int PX_WIDTH     = PH_WIDTH + 1;
    localparam int SUM_WIDTH    = COORD_WIDTH + 3;

    localparam logic signed [TS_WIDTH-1:0] T_ONE = TS_WIDTH'(1 << FRAC_BITS);
    localparam logic signed [TS_WIDTH-1:0] T_SAT = TS_WIDTH'(2 << FRAC_BITS);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] box_x;
        logic signed [COORD_WIDTH-1:0] box_y;
        logic [COORD_WIDTH-2:0]        box_w;
        logic [COORD_WIDTH-2:0]        box_h;
    } ray_in_t;

    typedef struct packed {
        logic                          hit;
        logic [TIME_WIDTH-1:0]         hit_time;
        logic signed [COORD_WIDTH-1:0] contact_x;
        logic signed [COORD_WIDTH-1:0] contact_y;
        logic signed [NORM_WIDTH-1:0]  normal_x;
        logic signed [NORM_WIDTH-1:0]  normal_y;
    } ray_out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ox;
        logic signed [COORD_WIDTH-1:0] oy;
        logic signed [COORD_WIDTH-1:0] dx;
        logic signed [COORD_WIDTH-1:0] dy;
    } geo_t;

    // One restoring divider lane
    typedef struct packed {
        logic [NUM_WIDTH-1:0]   r;
        logic [COORD_WIDTH-1:0] ud;
        logic [DIV_STEPS-1:0]   q;
        logic                   neg;
        logic                   sat;
        logic                   bad;
    } div_lane_t;

    // Result fields carried down the normal pipeline
    typedef struct packed {
        logic                          hit;
        logic [TIME_WIDTH-1:0]         t;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic                          ysel;
        logic                          sneg;
    } tail_t;

    // Bitwise search for the normal magnitude
    typedef struct packed {
        logic [ACC_WIDTH-1:0]   p;
        logic [ACC_WIDTH-1:0]   q;
        logic [ACC_WIDTH-1:0]   r;
        logic [S2_WIDTH-1:0]    s2;
        logic [NORM_BITS:0]     k;
        logic                   zero;
    } srch_t;

    // Set up a lane: magnitudes, sign, saturation and the undefined case
    function automatic div_lane_t lane_prep(logic signed [NUM_WIDTH-1:0] num,
                                            logic signed [COORD_WIDTH-1:0] den);
        div_lane_t              l;
        logic [NUM_WIDTH-1:0]   un;
        logic [COORD_WIDTH-1:0] ud;
        un     = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
        ud     = den[COORD_WIDTH-1] ? COORD_WIDTH'(-den) : COORD_WIDTH'(den);
        l.r    = un;
        l.ud   = ud;
        l.q    = '0;
        l.neg  = num[NUM_WIDTH-1] ^ den[COORD_WIDTH-1];
        l.sat  = (un >= NUM_WIDTH'({ud, 1'b0}));
        l.bad  = (den == '0) && (num == '0);
        return l;
    endfunction

    // One quotient bit; the integer bit takes no shift
    function automatic div_lane_t div_step(div_lane_t l, logic first);
        div_lane_t            o;
        logic [NUM_WIDTH-1:0] rs;
        o    = l;
        rs   = first ? l.r : {l.r[NUM_WIDTH-2:0], 1'b0};
        o.q  = first ? l.q : {l.q[DIV_STEPS-2:0], 1'b0};
        if (rs >= NUM_WIDTH'(l.ud))
        begin
            o.r    = rs - NUM_WIDTH'(l.ud);
            o.q[0] = 1'b1;
        end
        else
        begin
            o.r = rs;
        end
        return o;
    endfunction

    // Signed time from a finished lane
    function automatic logic signed [TS_WIDTH-1:0] lane_time(div_lane_t l);
        logic signed [TS_WIDTH-1:0] m;
        m = l.sat ? T_SAT : TS_WIDTH'(l.q);
        return l.neg ? -m : m;
    endfunction

    // Clamp a widened sum to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        logic signed [SUM_WIDTH-1:0] v);
        logic [SUM_WIDTH-COORD_WIDTH:0] top;
        top = v[SUM_WIDTH-1:COORD_WIDTH-1];
        if (top == '0 || top == '1)
            return v[COORD_WIDTH-1:0];
        else if (v[SUM_WIDTH-1])
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

    // Try one bit of k: keep it when (k + 2^b)^2 * s2 <= r
    function automatic srch_t srch_step(srch_t s, int bitpos);
        srch_t                o;
        logic [ACC_WIDTH-1:0] cand;
        o    = s;
        cand = s.p + (s.q << (bitpos + 1)) + (ACC_WIDTH'(s.s2) << (2 * bitpos));
        if (cand <= s.r)
        begin
            o.p         = cand;
            o.q         = s.q + (ACC_WIDTH'(s.s2) << bitpos);
            o.k[bitpos] = 1'b1;
        end
        return o;
    endfunction

endpackage

// ----- src/ray_box_slab_intersect.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid / in_ready       in_data  (ray_in_t: ray origin, direction, box)
// output    out_valid / out_ready     out_data (ray_out_t: hit, time, contact, normal)
//
// One transaction per cycle sustained while the output is not stalled.
// The pipeline holds the 17 pipelined quotient-bit stages of the four slab
// dividers and the 15 bit-search stages of the normal magnitude.
// Reset clears only the stage valid bits; data registers carry no reset.
// A stall on the output freezes every stage at once, so in_ready follows it.
module ray_box_slab_intersect (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rbsi_pkg::ray_in_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rbsi_pkg::ray_out_t out_data
);
    import rbsi_pkg::*;

    localparam int LAT = DIV_STEPS + SEARCH_STEPS + 9;

    logic           en;
    logic [LAT-1:0] vld_reg;

    // Stage registers
    geo_t                      s1_geo_reg;
    logic signed [NUM_WIDTH-1:0] s1_num_reg [4];
    div_lane_t [3:0]           prep;
    div_lane_t [3:0]           dv_reg [DIV_STEPS+1];
    geo_t                      dg_reg [DIV_STEPS+1];
    logic signed [TS_WIDTH-1:0] tm_reg [4];
    logic                      tbad_reg;
    geo_t                      tg_reg;

    logic signed [TS_WIDTH-1:0] nx, fx, ny, fy, tt;
    logic                      ev_hit_reg, ev_ysel_reg;
    logic [TIME_WIDTH-1:0]     ev_t_reg;
    geo_t                      eg_reg;

    logic [COORD_WIDTH-1:0]    mag_x, mag_y;
    logic [PH_WIDTH-1:0]       phx_reg, phy_reg;
    logic [PL_WIDTH-1:0]       plx_reg, ply_reg;
    logic [COORD_WIDTH-1:0]    ma_reg, mb_reg;
    tail_t                     mt_reg;
    geo_t                      mg_reg;

    logic [PX_WIDTH-1:0]       px, py;
    logic signed [SUM_WIDTH-1:0] sx, sy;
    logic [COORD_WIDTH-1:0]    ab;
    logic [SH_WIDTH-1:0]       sh;
    logic [MAG_BITS-1:0]       a16_reg, b16_reg;
    tail_t                     ct_next;
    tail_t                     ct_reg;

    logic [SQ_WIDTH-1:0]       aa_reg, bb_reg;
    tail_t                     ht_reg;

    srch_t                     sr_reg [SEARCH_STEPS+1];
    tail_t                     st_reg [SEARCH_STEPS+1];
    logic [S2_WIDTH-1:0]       s2;

    logic signed [NORM_WIDTH-1:0] norm;
    ray_out_t                  out_reg;

    // Advance the whole pipe unless the output holds a waiting transaction
    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Slab numerators: distance from origin to each edge line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_geo_reg.ox <= in_data.origin_x;
            s1_geo_reg.oy <= in_data.origin_y;
            s1_geo_reg.dx <= in_data.dir_x;
            s1_geo_reg.dy <= in_data.dir_y;
            s1_num_reg[0] <= NUM_WIDTH'(in_data.box_x) - NUM_WIDTH'(in_data.origin_x);
            s1_num_reg[1] <= NUM_WIDTH'(in_data.box_x) + NUM_WIDTH'(in_data.box_w)
                             - NUM_WIDTH'(in_data.origin_x);
            s1_num_reg[2] <= NUM_WIDTH'(in_data.box_y) - NUM_WIDTH'(in_data.origin_y);
            s1_num_reg[3] <= NUM_WIDTH'(in_data.box_y) + NUM_WIDTH'(in_data.box_h)
                             - NUM_WIDTH'(in_data.origin_y);
        end
    end

    // Load the four divider lanes
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prep[i] = lane_prep(s1_num_reg[i], (i < 2) ? s1_geo_reg.dx : s1_geo_reg.dy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= prep;
            dg_reg[0] <= s1_geo_reg;
        end
    end

    // Divider pipeline, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    dv_reg[j+1][i] <= div_step(dv_reg[j][i], j == 0);
                end
                dg_reg[j+1] <= dg_reg[j];
            end
        end
    end

    // Signed slab times
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tm_reg[i] <= lane_time(dv_reg[DIV_STEPS][i]);
            end
            tbad_reg <= dv_reg[DIV_STEPS][0].bad | dv_reg[DIV_STEPS][1].bad
                        | dv_reg[DIV_STEPS][2].bad | dv_reg[DIV_STEPS][3].bad;
            tg_reg   <= dg_reg[DIV_STEPS];
        end
    end

    // Order each slab pair and decide the hit
    always_comb
    begin
        nx = (tm_reg[1] < tm_reg[0]) ? tm_reg[1] : tm_reg[0];
        fx = (tm_reg[1] < tm_reg[0]) ? tm_reg[0] : tm_reg[1];
        ny = (tm_reg[3] < tm_reg[2]) ? tm_reg[3] : tm_reg[2];
        fy = (tm_reg[3] < tm_reg[2]) ? tm_reg[2] : tm_reg[3];
        tt = (nx > ny) ? nx : ny;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ev_hit_reg  <= !tbad_reg && (nx < fy) && (ny < fx)
                           && !tt[TS_WIDTH-1] && (tt <= T_ONE);
            ev_t_reg    <= tt[TIME_WIDTH-1:0];
            ev_ysel_reg <= (nx < ny);
            eg_reg      <= tg_reg;
        end
    end

    // Scale the direction by t in two partial products; pick the normal axis
    always_comb
    begin
        mag_x = eg_reg.dx[COORD_WIDTH-1] ? COORD_WIDTH'(-eg_reg.dx) : COORD_WIDTH'(eg_reg.dx);
        mag_y = eg_reg.dy[COORD_WIDTH-1] ? COORD_WIDTH'(-eg_reg.dy) : COORD_WIDTH'(eg_reg.dy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phx_reg     <= PH_WIDTH'(mag_x[COORD_WIDTH-1:FRAC_BITS]) * PH_WIDTH'(ev_t_reg);
            plx_reg     <= PL_WIDTH'(mag_x[FRAC_BITS-1:0]) * PL_WIDTH'(ev_t_reg);
            phy_reg     <= PH_WIDTH'(mag_y[COORD_WIDTH-1:FRAC_BITS]) * PH_WIDTH'(ev_t_reg);
            ply_reg     <= PL_WIDTH'(mag_y[FRAC_BITS-1:0]) * PL_WIDTH'(ev_t_reg);
            ma_reg      <= ev_ysel_reg ? mag_y : mag_x;
            mb_reg      <= ev_ysel_reg ? mag_x : mag_y;
            mt_reg.hit  <= ev_hit_reg;
            mt_reg.t    <= ev_t_reg;
            mt_reg.cx   <= '0;
            mt_reg.cy   <= '0;
            mt_reg.ysel <= ev_ysel_reg;
            mt_reg.sneg <= ev_ysel_reg ? eg_reg.dy[COORD_WIDTH-1] : eg_reg.dx[COORD_WIDTH-1];
            mg_reg      <= eg_reg;
        end
    end

    // Contact point and normal prescale
    always_comb
    begin
        px = PX_WIDTH'(phx_reg) + PX_WIDTH'(plx_reg >> FRAC_BITS);
        py = PX_WIDTH'(phy_reg) + PX_WIDTH'(ply_reg >> FRAC_BITS);
        sx = mg_reg.dx[COORD_WIDTH-1] ? SUM_WIDTH'(mg_reg.ox) - SUM_WIDTH'(px)
                                      : SUM_WIDTH'(mg_reg.ox) + SUM_WIDTH'(px);
        sy = mg_reg.dy[COORD_WIDTH-1] ? SUM_WIDTH'(mg_reg.oy) - SUM_WIDTH'(py)
                                      : SUM_WIDTH'(mg_reg.oy) + SUM_WIDTH'(py);
        ab = ma_reg | mb_reg;
        sh = '0;
        for (int k = 0; k < COORD_WIDTH - MAG_BITS; k++)
        begin
            if (ab[MAG_BITS+k])
                sh = SH_WIDTH'(k + 1);
        end
        ct_next    = mt_reg;
        ct_next.cx = sat_coord(sx);
        ct_next.cy = sat_coord(sy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a16_reg <= MAG_BITS'(ma_reg >> sh);
            b16_reg <= MAG_BITS'(mb_reg >> sh);
            ct_reg  <= ct_next;
        end
    end

    // Squares of the prescaled magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg <= SQ_WIDTH'(a16_reg) * SQ_WIDTH'(a16_reg);
            bb_reg <= SQ_WIDTH'(b16_reg) * SQ_WIDTH'(b16_reg);
            ht_reg <= ct_reg;
        end
    end

    // Seed the search
    assign s2 = S2_WIDTH'(aa_reg) + S2_WIDTH'(bb_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0].p    <= '0;
            sr_reg[0].q    <= '0;
            sr_reg[0].r    <= ACC_WIDTH'(aa_reg) << (2 * NORM_BITS);
            sr_reg[0].s2   <= s2;
            sr_reg[0].k    <= '0;
            sr_reg[0].zero <= (s2 == '0);
            st_reg[0]      <= ht_reg;
        end
    end

    // Search pipeline, most significant bit first
    for (genvar j = 0; j < SEARCH_STEPS; j++)
    begin : g_srch
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg[j+1] <= srch_step(sr_reg[j], SEARCH_STEPS - 1 - j);
                st_reg[j+1] <= st_reg[j];
            end
        end
    end

    // Sign the normal and drop everything on a miss
    always_comb
    begin
        if (sr_reg[SEARCH_STEPS].zero)
            norm = '0;
        else if (st_reg[SEARCH_STEPS].sneg)
            norm = NORM_WIDTH'(sr_reg[SEARCH_STEPS].k);
        else
            norm = -NORM_WIDTH'(sr_reg[SEARCH_STEPS].k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (st_reg[SEARCH_STEPS].hit)
            begin
                out_reg.hit       <= 1'b1;
                out_reg.hit_time  <= st_reg[SEARCH_STEPS].t;
                out_reg.contact_x <= st_reg[SEARCH_STEPS].cx;
                out_reg.contact_y <= st_reg[SEARCH_STEPS].cy;
                out_reg.normal_x  <= st_reg[SEARCH_STEPS].ysel ? '0 : norm;
                out_reg.normal_y  <= st_reg[SEARCH_STEPS].ysel ? norm : '0;
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

endmodule

// ----- src/rbsi_checker.sv -----
`timescale 1ns / 1ps

module rbsi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input rbsi_pkg::ray_in_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input rbsi_pkg::ray_out_t out_data
);
    import rbsi_pkg::*;

    // Hold a waiting input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed while waiting");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // Stall reaches the input side
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // Miss clears every field
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data == '0)
        else $error("miss with nonzero fields");

    // Hit time in range, normal on one axis only
    a_hit_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |->
            (out_data.hit_time <= TIME_WIDTH'(1 << FRAC_BITS))
            && (out_data.normal_x == '0 || out_data.normal_y == '0))
        else $error("malformed hit result");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rbsi_pkg::*;

    localparam int LATENCY   = 41;
    localparam int WD_LIMIT  = 20000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    ray_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    ray_out_t out_data;

    ray_out_t expected_hits[$];
    int       errors = 0;
    int       sent = 0;
    int       received = 0;
    int       hits_seen = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       idle_cycles = 0;

    ray_box_slab_intersect dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Slab crossing time, saturated to +-2.0; bad flags 0/0
    function automatic longint slab_time(longint num, longint den, ref bit bad);
        longint unsigned un, ud, q, r;
        if (den == 0)
        begin
            if (num == 0)
            begin
                bad = 1'b1;
                return 0;
            end
            return (num > 0) ? (64'sd2 <<< FRAC_BITS) : -(64'sd2 <<< FRAC_BITS);
        end
        un = mag64(num);
        ud = mag64(den);
        if (un >= 2 * ud)
            q = 64'd2 << FRAC_BITS;
        else
        begin
            q = 0;
            r = un;
            if (r >= ud)
            begin
                q = 1;
                r -= ud;
            end
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= ud)
                begin
                    r -= ud;
                    q |= 1;
                end
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint scale_dir(longint d, longint t);
        longint unsigned ud, p;
        ud = mag64(d);
        p = (ud >> FRAC_BITS) * t + (((ud & 64'hFFFF) * t) >> FRAC_BITS);
        return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint normal_comp(longint sel, longint other);
        longint unsigned a, b, s2, rhs, lo, hi, mid;
        a = mag64(sel);
        b = mag64(other);
        while (a >= 65536 || b >= 65536)
        begin
            a = a >> 1;
            b = b >> 1;
        end
        s2 = a * a + b * b;
        if (s2 == 0)
            return 0;
        rhs = a * a * (64'd16384 * 64'd16384);
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * s2 <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (sel < 0) ? longint'(lo) : -longint'(lo);
    endfunction

    function automatic ray_out_t predict_intersect(ray_in_t r);
        ray_out_t o;
        longint   ox, oy, dx, dy, bx, by, bw, bh, nx, ny, fx, fy, tmp, t;
        bit       bad;
        o = '0;
        bad = 1'b0;
        ox = longint'(r.origin_x);
        oy = longint'(r.origin_y);
        dx = longint'(r.dir_x);
        dy = longint'(r.dir_y);
        bx = longint'(r.box_x);
        by = longint'(r.box_y);
        bw = longint'({1'b0, r.box_w});
        bh = longint'({1'b0, r.box_h});
        nx = slab_time(bx - ox, dx, bad);
        fx = slab_time(bx + bw - ox, dx, bad);
        ny = slab_time(by - oy, dy, bad);
        fy = slab_time(by + bh - oy, dy, bad);
        if (bad)
            return o;
        if (fx < nx)
        begin
            tmp = nx; nx = fx; fx = tmp;
        end
        if (fy < ny)
        begin
            tmp = ny; ny = fy; fy = tmp;
        end
        if (!(nx < fy && ny < fx))
            return o;
        t = (nx > ny) ? nx : ny;
        if (t < 0 || t > (64'sd1 <<< FRAC_BITS))
            return o;
        o.hit = 1'b1;
        o.hit_time = t[TIME_WIDTH-1:0];
        o.contact_x = COORD_WIDTH'(clamp_coord(ox + scale_dir(dx, t)));
        o.contact_y = COORD_WIDTH'(clamp_coord(oy + scale_dir(dy, t)));
        if (nx < ny)
            o.normal_y = NORM_WIDTH'(normal_comp(dy, dx));
        else
            o.normal_x = NORM_WIDTH'(normal_comp(dx, dy));
        return o;
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_ray(ray_in_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= r;
        in_valid <= 1'b1;
        expected_hits.push_back(predict_intersect(r));
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return 32'h7FFFFFFF;
            3: return 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    // Mostly rays aimed near a box so hits are common
    function automatic ray_in_t rand_ray();
        ray_in_t r;
        r.origin_x = rand_coord();
        r.origin_y = rand_coord();
        r.dir_x = rand_coord();
        r.dir_y = rand_coord();
        r.box_x = rand_coord();
        r.box_y = rand_coord();
        r.box_w = 31'($urandom);
        r.box_h = 31'($urandom);
        if ($urandom_range(3) != 0)
        begin
            r.origin_x = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            r.origin_y = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            r.box_w = 31'($urandom_range(0, 1 << 18));
            r.box_h = 31'($urandom_range(0, 1 << 18));
            r.box_x = r.origin_x + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            r.box_y = r.origin_y + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            r.dir_x = ($urandom_range(9) == 0) ? 32'd0 :
                      r.box_x + 32'(r.box_w >> 1) - r.origin_x + 32'($urandom_range(0, 4096));
            r.dir_y = ($urandom_range(9) == 0) ? 32'd0 :
                      r.box_y + 32'(r.box_h >> 1) - r.origin_y + 32'($urandom_range(0, 4096));
        end
        return r;
    endfunction

    function automatic ray_in_t make_ray(int ox, int oy, int dx, int dy,
                                         int bx, int by, int bw, int bh);
        ray_in_t r;
        r.origin_x = ox; r.origin_y = oy; r.dir_x = dx; r.dir_y = dy;
        r.box_x = bx; r.box_y = by; r.box_w = 31'(bw); r.box_h = 31'(bh);
        return r;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
    endtask

    // Hits from each side, grazing, zero direction, edge-on, extremes
    task automatic test_directed();
        localparam int ONE = 1 << 16;
        send_ray(make_ray(0, 0, 4 * ONE, 0, 2 * ONE, -ONE, ONE, 2 * ONE));
        send_ray(make_ray(0, 0, -4 * ONE, 0, -3 * ONE, -ONE, ONE, 2 * ONE));
        send_ray(make_ray(0, 0, 0, 4 * ONE, -ONE, 2 * ONE, 2 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, -4 * ONE, -ONE, -3 * ONE, 2 * ONE, ONE));
        send_ray(make_ray(0, 0, 3 * ONE, 3 * ONE, ONE, ONE, ONE, ONE));
        send_ray(make_ray(0, 0, 3 * ONE, 2 * ONE, ONE, 0, ONE, ONE));
        send_ray(make_ray(0, 0, ONE, 0, ONE, -ONE, ONE, 2 * ONE));
        send_ray(make_ray(0, -ONE, ONE, 0, 0, -ONE, ONE, 2 * ONE));
        send_ray(make_ray(0, 0, 0, 0, ONE, ONE, ONE, ONE));
        send_ray(make_ray(2 * ONE, 2 * ONE, 0, 0, ONE, ONE, 4 * ONE, 4 * ONE));
        send_ray(make_ray(0, 0, ONE, ONE, -ONE, -ONE, 4 * ONE, 4 * ONE));
        send_ray(make_ray(0, 0, ONE, 0, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, ONE / 2, 0, 2 * ONE, 0, ONE, ONE));
        send_ray(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF));
        send_ray(make_ray(32'h80000000, 0, 32'h7FFFFFFF, 1, 0, -ONE, ONE, 2 * ONE));
        send_ray(make_ray(-1, -1, 32'hFFFFFFFF, 32'h80000001, -ONE, -ONE, 32'h7FFFFFFF, 1));
        send_ray(make_ray(0, 0, 5 * ONE, 1, ONE, -ONE, ONE, 2 * ONE));
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            send_ray(rand_ray());
            // Hold off once per phase until the pipeline empties
            if (i == count / 2)
                wait_drained();
        end
    endtask

    // Receiver readiness, changed at the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                ray_out_t e;
                e = expected_hits.pop_front();
                if (e !== out_data)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                    errors++;
                end
                hits_seen += e.hit;
            end
            received++;
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 72;
        test_directed();
        test_random(250, 33, 72);
        test_random(250, 72, 33);
        test_random(250, 0, 0);
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d rays, checked %0d results, %0d of them hits,", sent, received,
                 hits_seen);
        $display("across directed cases and three idle mixes.");
        if (errors == 0 && expected_hits.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
